// ----- hw/rtl/cvxh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvxh_pkg: shared types for the gift-wrap convex hull block
// Item structs for both channels, the stored point pair and the control
// bundle that drives the shared cross-product unit.
// ----------------------------------------------------------------------------
package cvxh_pkg;

  localparam int COORD_W = 16;
  localparam int VIDX_W  = 6;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int ACC_W   = PROD_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic [VIDX_W-1:0]         vertex_index;
    logic                      last_vertex;
    logic                      bound_hit;
  } vertex_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_t;

  // Steps of one cross-product evaluation, one per cycle.
  typedef struct packed {
    logic load;      // latch the coordinate differences
    logic mul_first; // acc = dix * dqy
    logic mul_second; // acc = acc - diy * dqx
  } cross_ctl_t;

endpackage

// ----- hw/rtl/cvxh_cross.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvxh_cross: shared cross-product unit
// Evaluates (Pi - Pp) x (Pq - Pp) with one signed 17x17 multiplier, taking
// the two products in turn, and flags a strictly positive result.
// ----------------------------------------------------------------------------
module cvxh_cross (
  input  logic                 clk,
  input  cvxh_pkg::cross_ctl_t ctl,
  input  cvxh_pkg::coord_t     pt_p,
  input  cvxh_pkg::coord_t     pt_i,
  input  cvxh_pkg::coord_t     pt_q,
  output logic                 positive
);

  logic signed [cvxh_pkg::DIFF_W-1:0] dix, diy, dqx, dqy;
  logic signed [cvxh_pkg::DIFF_W-1:0] mul_a, mul_b;
  logic signed [cvxh_pkg::PROD_W-1:0] prod;
  logic signed [cvxh_pkg::ACC_W-1:0]  acc;

  // Operand select for the single multiplier.
  assign mul_a = ctl.mul_second ? diy : dix;
  assign mul_b = ctl.mul_second ? dqx : dqy;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dix <= $signed({pt_i.x[cvxh_pkg::COORD_W-1], pt_i.x})
           - $signed({pt_p.x[cvxh_pkg::COORD_W-1], pt_p.x});
      diy <= $signed({pt_i.y[cvxh_pkg::COORD_W-1], pt_i.y})
           - $signed({pt_p.y[cvxh_pkg::COORD_W-1], pt_p.y});
      dqx <= $signed({pt_q.x[cvxh_pkg::COORD_W-1], pt_q.x})
           - $signed({pt_p.x[cvxh_pkg::COORD_W-1], pt_p.x});
      dqy <= $signed({pt_q.y[cvxh_pkg::COORD_W-1], pt_q.y})
           - $signed({pt_p.y[cvxh_pkg::COORD_W-1], pt_p.y});
    end
    if (ctl.mul_first) begin
      acc <= cvxh_pkg::ACC_W'(prod);
    end else if (ctl.mul_second) begin
      acc <= acc - cvxh_pkg::ACC_W'(prod);
    end
  end

  assign positive = (acc > $signed({cvxh_pkg::ACC_W{1'b0}}));

endmodule

// ----- hw/rtl/convex_hull_gift_wrap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap: convex hull of a point set by gift wrapping
// Loads signed Q7.8 points, then walks the hull and emits its vertices.
// ----------------------------------------------------------------------------
// Usage:
//   point channel  : one point per item, accepted while point_stall is low.
//   Plain points load back to back. An item with last_point set is
//   stored too and starts the hull walk; point_stall stays high until the
//   last vertex of the set has been placed in the output register.
//   vertex channel : one item per hull vertex in walk order, starting at the
//   leftmost point (lowest index on ties). last_vertex marks the final one;
//   bound_hit is set on every vertex of a set that dropped points or hit the
//   vertex limit. Sets of one or two points come back as loaded.
//   Steps after the last item: a leftmost search with one store read per
//   point; per vertex, a load of the first candidate (ST_VERT, ST_Q_RD,
//   ST_Q_LD) and a test of each point (ST_C_RD to ST_C_CMP) through the
//   single shared multiplier of the cross-product unit; then a read-back
//   and emit of each vertex, plus any stall time on the vertex channel.
//   A stalled vertex item holds in the output register; the sequencer waits
//   for it before loading the next one. The next set may start loading while
//   the final vertex item still waits.
//   Reset (rst, synchronous) empties the point store and clears the flags;
//   store contents are not cleared since only written entries are read.
// ----------------------------------------------------------------------------
module convex_hull_gift_wrap #(
  parameter int MAX_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  output logic                   point_stall,
  input  cvxh_pkg::point_item_t  point,
  output logic                   vertex_valid,
  input  logic                   vertex_stall,
  output cvxh_pkg::vertex_item_t vertex
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_VERT,
    ST_Q_RD,
    ST_Q_LD,
    ST_C_RD,
    ST_C_DIFF,
    ST_C_MUL1,
    ST_C_MUL2,
    ST_C_CMP,
    ST_E_RD,
    ST_E_PT,
    ST_E_OUT
  } state_t;

  state_t state;

  // Point store and walk results.
  cvxh_pkg::coord_t pt_mem [MAX_POINTS];
  logic [IW-1:0]    vtx_mem [MAX_POINTS];
  cvxh_pkg::coord_t rd_pt;
  logic [IW-1:0]    rd_addr;
  logic             rd_en;
  logic [IW-1:0]    vtx_rd;

  // Set bookkeeping.
  logic [CW-1:0] count;
  logic          overflow;
  logic          hit;
  logic          direct;
  logic [CW-1:0] nv;

  // Walk registers.
  logic [IW-1:0]    i;
  logic [IW-1:0]    l;
  logic [IW-1:0]    p;
  logic [IW-1:0]    q;
  cvxh_pkg::coord_t pt_p;
  cvxh_pkg::coord_t pt_q;
  logic [IW-1:0]    k;
  logic [IW-1:0]    e_idx;

  // Shared cross-product unit.
  cvxh_pkg::cross_ctl_t xctl;
  logic                 xpos;

  // Derived terms.
  logic          in_accept;
  logic          full;
  logic [CW-1:0] count_new;
  logic          overflow_new;
  logic          i_last;
  logic [IW-1:0] p_inc;
  logic          find_upd;
  logic [IW-1:0] q_new;
  cvxh_pkg::coord_t pt_q_new;
  logic          out_free;
  logic          out_load;
  logic          k_last;
  logic [IW-1:0] e_sel;

  assign point_stall  = (state != ST_IDLE);
  assign in_accept    = point_valid && !point_stall;
  assign full         = (count >= CW'(MAX_POINTS));
  assign count_new    = full ? count : count + CW'(1);
  assign overflow_new = overflow || full;

  assign i_last   = (CW'(i) + CW'(1) == count);
  assign p_inc    = (CW'(p) + CW'(1) == count) ? '0 : p + IW'(1);
  assign find_upd = (i == '0) || (rd_pt.x < pt_p.x);
  assign q_new    = xpos ? i : q;
  assign pt_q_new = xpos ? rd_pt : pt_q;

  assign out_free = !vertex_valid || !vertex_stall;
  assign out_load = (state == ST_E_OUT) && out_free;
  assign k_last   = (CW'(k) + CW'(1) == nv);
  assign e_sel    = direct ? k : vtx_rd;

  // Read address of the point store for each reading state.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i;
    case (state)
      ST_FIND_RD, ST_C_RD: begin
        rd_en   = 1'b1;
        rd_addr = i;
      end
      ST_Q_RD: begin
        rd_en   = 1'b1;
        rd_addr = q;
      end
      ST_E_PT: begin
        rd_en   = 1'b1;
        rd_addr = e_sel;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = i;
      end
    endcase
  end

  always_comb begin
    xctl            = '0;
    xctl.load       = (state == ST_C_DIFF);
    xctl.mul_first  = (state == ST_C_MUL1);
    xctl.mul_second = (state == ST_C_MUL2);
  end

  cvxh_cross u_cross (
    .clk      (clk),
    .ctl      (xctl),
    .pt_p     (pt_p),
    .pt_i     (rd_pt),
    .pt_q     (pt_q),
    .positive (xpos)
  );

  // Point store: write on load, registered read.
  always_ff @(posedge clk) begin
    if (in_accept && !full) begin
      pt_mem[count[IW-1:0]] <= '{x: point.point_x, y: point.point_y};
    end
    if (rd_en) begin
      rd_pt <= pt_mem[rd_addr];
    end
  end

  // Vertex list: append during the walk, read back while emitting.
  always_ff @(posedge clk) begin
    if ((state == ST_VERT) && (nv != CW'(MAX_POINTS))) begin
      vtx_mem[nv[IW-1:0]] <= p;
    end
    if (state == ST_E_RD) begin
      vtx_rd <= vtx_mem[k];
    end
  end

  // Sequencer, set bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      overflow     <= 1'b0;
      vertex_valid <= 1'b0;
    end else begin
      // Raise valid with a new result; drop it once the receiver takes it.
      if (out_load) begin
        vertex_valid <= 1'b1;
      end else if (!vertex_stall) begin
        vertex_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            count    <= count_new;
            overflow <= overflow_new;
            if (point.last_point) begin
              hit <= overflow_new;
              k   <= '0;
              i   <= '0;
              if (count_new < CW'(3)) begin
                direct <= 1'b1;
                nv     <= count_new;
                state  <= ST_E_RD;
              end else begin
                direct <= 1'b0;
                nv     <= '0;
                state  <= ST_FIND_RD;
              end
            end
          end
        end

        ST_FIND_RD: begin
          state <= ST_FIND_CMP;
        end

        // Track the leftmost point in l / pt_p; strict compare keeps the
        // lowest index on ties.
        ST_FIND_CMP: begin
          if (find_upd) begin
            l    <= i;
            pt_p <= rd_pt;
          end
          if (i_last) begin
            p     <= find_upd ? i : l;
            state <= ST_VERT;
          end else begin
            i     <= i + IW'(1);
            state <= ST_FIND_RD;
          end
        end

        // Record p as a vertex, or stop at the vertex limit.
        ST_VERT: begin
          if (nv == CW'(MAX_POINTS)) begin
            hit   <= 1'b1;
            k     <= '0;
            state <= ST_E_RD;
          end else begin
            nv    <= nv + CW'(1);
            q     <= p_inc;
            state <= ST_Q_RD;
          end
        end

        ST_Q_RD: begin
          state <= ST_Q_LD;
        end

        ST_Q_LD: begin
          pt_q  <= rd_pt;
          i     <= '0;
          state <= ST_C_RD;
        end

        ST_C_RD: begin
          state <= ST_C_DIFF;
        end

        ST_C_DIFF: begin
          state <= ST_C_MUL1;
        end

        ST_C_MUL1: begin
          state <= ST_C_MUL2;
        end

        ST_C_MUL2: begin
          state <= ST_C_CMP;
        end

        // Replace the candidate on a strictly positive cross product.
        ST_C_CMP: begin
          q    <= q_new;
          pt_q <= pt_q_new;
          if (i_last) begin
            p    <= q_new;
            pt_p <= pt_q_new;
            if (q_new == l) begin
              k     <= '0;
              state <= ST_E_RD;
            end else begin
              state <= ST_VERT;
            end
          end else begin
            i     <= i + IW'(1);
            state <= ST_C_RD;
          end
        end

        ST_E_RD: begin
          state <= ST_E_PT;
        end

        ST_E_PT: begin
          e_idx <= e_sel;
          state <= ST_E_OUT;
        end

        // Hold here until the output register is free.
        ST_E_OUT: begin
          if (out_free) begin
            vertex.vertex_x     <= rd_pt.x;
            vertex.vertex_y     <= rd_pt.y;
            vertex.vertex_index <= cvxh_pkg::VIDX_W'(e_idx);
            vertex.last_vertex  <= k_last;
            vertex.bound_hit    <= hit;
            if (k_last) begin
              count    <= '0;
              overflow <= 1'b0;
              state    <= ST_IDLE;
            end else begin
              k     <= k + IW'(1);
              state <= ST_E_RD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_vert_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_VERT) |-> (nv <= CW'(MAX_POINTS)))
    else $error("vertex count beyond limit");

  a_end_of_set: assert property (@(posedge clk) disable iff (rst)
    (out_load && k_last) |=> ((state == ST_IDLE) && (count == '0) && !overflow))
    else $error("set not cleared after final vertex");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (CW'(e_idx) < count))
    else $error("emitted vertex index outside loaded set");

endmodule

// ----- tb/sv/hull_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hull_checker: hull vertex predictor and scoreboard
// Watches both channels of the gift-wrap hull block, keeps its own copy of
// the point store, computes the expected vertex items for each set and
// compares every vertex item against the oldest expected one.
// ----------------------------------------------------------------------------
module hull_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  input  logic                   point_stall,
  input  cvxh_pkg::point_item_t  point,
  input  logic                   vertex_valid,
  input  logic                   vertex_stall,
  input  cvxh_pkg::vertex_item_t vertex,
  output int                     errors,
  output int                     pending
);

  logic signed [cvxh_pkg::COORD_W-1:0] set_x [MAX_POINTS];
  logic signed [cvxh_pkg::COORD_W-1:0] set_y [MAX_POINTS];
  int                                  kept;
  bit                                  dropped;
  cvxh_pkg::vertex_item_t              hull_q [$];

  // Cross product (b - a) x (c - a); positive when b should replace c as
  // the wrap candidate.
  function automatic longint turn(int a, int b, int c);
    longint bx, by, cx, cy;
    bx = set_x[b] - set_x[a];
    by = set_y[b] - set_y[a];
    cx = set_x[c] - set_x[a];
    cy = set_y[c] - set_y[a];
    return bx * cy - by * cx;
  endfunction

  task automatic queue_vertex(int idx, bit lastv, bit hit);
    cvxh_pkg::vertex_item_t v;
    v.vertex_x     = set_x[idx];
    v.vertex_y     = set_y[idx];
    v.vertex_index = cvxh_pkg::VIDX_W'(idx);
    v.last_vertex  = lastv;
    v.bound_hit    = hit;
    hull_q = {hull_q, v};
  endtask

  // Walk the hull of the kept points and queue one vertex item per vertex.
  task automatic wrap_hull();
    int walk [$];
    int n, l, p, q;
    bit hit;
    n   = kept;
    hit = dropped;
    if (n < 3) begin
      for (int i = 0; i < n; i++) queue_vertex(i, i == n - 1, hit);
    end else begin
      l = 0;
      for (int i = 1; i < n; i++) if (set_x[i] < set_x[l]) l = i;
      p = l;
      do begin
        if (walk.size() >= MAX_POINTS) begin
          hit = 1'b1;
          break;
        end
        walk = {walk, p};
        q = (p + 1) % n;
        for (int i = 0; i < n; i++) if (turn(p, i, q) > 0) q = i;
        p = q;
      end while (p != l);
      foreach (walk[i]) queue_vertex(walk[i], i == walk.size() - 1, hit);
    end
    kept    = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    cvxh_pkg::vertex_item_t want;
    if (rst) begin
      kept    = 0;
      dropped = 1'b0;
      hull_q.delete();
      errors  = 0;
    end else begin
      if (vertex_valid && !vertex_stall) begin
        if (hull_q.size() == 0) begin
          $error("unexpected vertex item: x=%0d y=%0d index=%0d",
                 vertex.vertex_x, vertex.vertex_y, vertex.vertex_index);
          errors++;
        end else begin
          want = hull_q.pop_front();
          if (vertex.vertex_x !== want.vertex_x) begin
            $error("vertex_x: expected %0d, got %0d", want.vertex_x, vertex.vertex_x);
            errors++;
          end
          if (vertex.vertex_y !== want.vertex_y) begin
            $error("vertex_y: expected %0d, got %0d", want.vertex_y, vertex.vertex_y);
            errors++;
          end
          if (vertex.vertex_index !== want.vertex_index) begin
            $error("vertex_index: expected %0d, got %0d",
                   want.vertex_index, vertex.vertex_index);
            errors++;
          end
          if (vertex.last_vertex !== want.last_vertex) begin
            $error("last_vertex: expected %0b, got %0b",
                   want.last_vertex, vertex.last_vertex);
            errors++;
          end
          if (vertex.bound_hit !== want.bound_hit) begin
            $error("bound_hit: expected %0b, got %0b", want.bound_hit, vertex.bound_hit);
            errors++;
          end
        end
      end
      if (point_valid && !point_stall) begin
        if (kept < MAX_POINTS) begin
          set_x[kept] = point.point_x;
          set_y[kept] = point.point_y;
          kept++;
        end else begin
          dropped = 1'b1;
        end
        if (point.last_point) wrap_hull();
      end
    end
    pending = hull_q.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: gift-wrap convex hull testbench
// Feeds point sets to the hull block, directed corner sets first and then
// random sets of mixed size and spread, with random gaps on the point side
// and random stalls on the vertex side. The hull checker predicts and
// compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_PTS      = 64;
  localparam int TOTAL_ITEMS  = 370;
  // Longest quiet stretch of a correct run is one full 64-point walk that
  // hits the vertex limit. Allow ~5x that.
  localparam int IDLE_LIMIT   = 100000;
  localparam int DRAIN_CYCLES = 200;

  // Coordinate spreads for random sets.
  typedef enum int {
    SPREAD_FULL,  // whole Q7.8 range
    SPREAD_GRID,  // tiny grid: duplicates and collinear runs
    SPREAD_EDGE,  // range extremes and values around zero
    SPREAD_NEAR   // a few metres around the origin
  } spread_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   point_valid  = 1'b0;
  logic                   point_stall;
  cvxh_pkg::point_item_t  point        = '0;
  logic                   vertex_valid;
  logic                   vertex_stall = 1'b0;
  cvxh_pkg::vertex_item_t vertex;

  int mismatches;
  int outstanding;
  bit calm        = 1'b0;  // set for stretches with no gaps or stalls
  int stall_left  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;

  convex_hull_gift_wrap #(.MAX_POINTS(MAX_PTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex)
  );

  hull_checker #(.MAX_POINTS(MAX_PTS)) hull_chk (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .errors       (mismatches),
    .pending      (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [cvxh_pkg::COORD_W-1:0] pick_coord(spread_t spread);
    int v;
    case (spread)
      SPREAD_FULL: v = $urandom;
      SPREAD_GRID: v = $urandom_range(0, 6) - 3;
      SPREAD_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          3:       v = 0;
          default: v = 1;
        endcase
      end
      default:     v = $urandom_range(0, 1200) - 600;
    endcase
    return v[cvxh_pkg::COORD_W-1:0];
  endfunction

  // Offer one point item, with an optional gap before it, and hold it until
  // the block takes it. Keep valid high across back-to-back items.
  task automatic send_point(input logic signed [cvxh_pkg::COORD_W-1:0] x,
                            input logic signed [cvxh_pkg::COORD_W-1:0] y,
                            input logic last);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point       <= '{point_x: x, point_y: y, last_point: last};
    do @(posedge clk); while (point_stall);
    items_sent++;
  endtask

  // Vertex side: stall in random bursts, independent of vertex_valid.
  always @(posedge clk) begin
    if (rst) begin
      stall_left   = 0;
      vertex_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      vertex_stall <= 1'b1;
    end else begin
      vertex_stall <= 1'b0;
      if (!calm && $urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (vertex_valid && !vertex_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int      n;
    int      kind;
    int      set_no;
    spread_t spread;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Single point: comes back as loaded, at the range corner.
    send_point(32767, -32768, 1'b1);
    // Two points: come back in load order.
    send_point(-32768, 32767, 1'b0);
    send_point(0, 0, 1'b1);
    // Full-range square with a collinear point on the bottom edge and one
    // inside: widest coordinate differences through the cross product.
    send_point(-32768, -32768, 1'b0);
    send_point(32767, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(-32768, 32767, 1'b0);
    send_point(0, -32768, 1'b0);
    send_point(100, -50, 1'b1);
    // Leftmost point in the middle of a vertical edge: the walk skips it,
    // never returns to the start and runs into the vertex limit.
    send_point(0, 512, 1'b0);
    send_point(1024, 512, 1'b0);
    send_point(0, 1024, 1'b0);
    send_point(0, 0, 1'b1);
    // Duplicate points only.
    send_point(256, 256, 1'b0);
    send_point(256, 256, 1'b0);
    send_point(256, 256, 1'b1);
    // All points on one line: zero cross products everywhere.
    send_point(-5, -5, 1'b0);
    send_point(10, 10, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(20, 20, 1'b1);
    // Tie on the leftmost x: start from the lower index.
    send_point(-7, 3, 1'b0);
    send_point(-7, -3, 1'b0);
    send_point(5, 0, 1'b1);

    // Random sets: mostly small, some mid-size, a few near the store size,
    // and two that overflow it (one drops exactly the last item).
    set_no = 0;
    while (items_sent < TOTAL_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (set_no == 4)       n = MAX_PTS + 1;
      else if (set_no == 15) n = MAX_PTS + 6;
      else if (kind < 60)    n = $urandom_range(1, 8);
      else if (kind < 88)    n = $urandom_range(9, 24);
      else                   n = $urandom_range(25, MAX_PTS);
      spread = spread_t'($urandom_range(0, 3));
      calm   = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < n; i++) begin
        send_point(pick_coord(spread), pick_coord(spread), i == n - 1);
      end
      set_no++;
    end
    point_valid <= 1'b0;
    calm = 1'b0;

    // Sample the checker's count away from the driving edge.
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
